@@ src/assert_macros.svh @@
// Assertion macros used by the bound checker in src/ifla_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that is checked at every rising clock edge outside reset.
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// The same check, also active while reset is held.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/ifla_pkg.sv @@
package ifla_pkg;

    localparam int MAX_PAGES_DEF  = 4;
    localparam int WORDS_PER_PAGE = 1024;
    localparam int HEAP_PAGES_RST = 4;
    localparam int TAG_W          = 15;
    localparam int SIZE_W         = 14;
    localparam int BASE_W         = 20;
    localparam int PAGE_SHIFT     = 12;
    localparam int CFG_W          = 20;

    // Register indexes of the configuration port.
    localparam logic REG_BASE  = 1'b0;
    localparam logic REG_PAGES = 1'b1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_BAD   = 2'd1,
        STAT_NOFIT = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_F_RD,
        ST_F_CHK,
        ST_F_W2,
        ST_M_RD,
        ST_M_CHK,
        ST_M_NXT,
        ST_M_W1,
        ST_M_W2,
        ST_A_RD,
        ST_A_CHK,
        ST_A_W2,
        ST_A_W3,
        ST_A_W4,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic        valid;
        status_t     status;
        logic [31:0] addr;
    } done_t;

endpackage

@@ src/implicit_free_list_allocator.sv @@
// Channel  | Handshake          | Word
// ---------+--------------------+-------------------------------------------------
// s_       | s_valid / s_ready  | s_operation, s_request_bytes, s_address
// m_       | m_valid / m_ready  | m_status, m_payload_address
// cfg_     | cfg_we, no stall   | cfg_index, cfg_wdata
//
// One request at a time. An allocate or free walks the block list in the tag RAM,
// reading each block visited, checking the neighbor of each free block and
// rewriting both end tags per merge, so the time taken follows the number of blocks
// in the heap; a zero-size or bad-address request goes straight to its result. After
// reset and after each heap_pages write a clearing pass writes all 4096 tag words
// (one per cycle) while s_ready stays low.
// A finished word waits in the output register while the next request is taken.
module implicit_free_list_allocator
    import ifla_pkg::*;
#(
    parameter int MAX_PAGES = MAX_PAGES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_operation,
    input  logic [13:0]      s_request_bytes,
    input  logic [31:0]      s_address,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_status,
    output logic [31:0]      m_payload_address,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int AW       = $clog2(MAX_PAGES * WORDS_PER_PAGE);
    localparam int RST_PGS  = (HEAP_PAGES_RST > MAX_PAGES) ? MAX_PAGES : HEAP_PAGES_RST;

    logic [BASE_W-1:0] base_reg;
    logic [AW:0]       n_reg;
    logic              m_valid_reg;
    status_t           m_status_reg;
    logic [31:0]       m_addr_reg;
    logic              restart, out_free;
    int                pages;
    done_t             done;

    assign restart  = cfg_we && (cfg_index == REG_PAGES);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        pages = int'(cfg_wdata[2:0]);
        if (pages == 0) begin
            pages = 1;
        end
        if (pages > MAX_PAGES) begin
            pages = MAX_PAGES;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            n_reg    <= (AW+1)'(RST_PGS * WORDS_PER_PAGE);
        end else if (cfg_we) begin
            if (cfg_index == REG_BASE) begin
                base_reg <= cfg_wdata[BASE_W-1:0];
            end else begin
                n_reg <= (AW+1)'(pages * WORDS_PER_PAGE);
            end
        end
    end

    ifla_engine #(.MAX_PAGES(MAX_PAGES)) u_engine (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .restart         (restart),
        .n_words         (n_reg),
        .base_page       (base_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_request_bytes (s_request_bytes),
        .s_address       (s_address),
        .out_free        (out_free),
        .done            (done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done.valid && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done.valid && out_free) begin
            m_status_reg <= done.status;
            m_addr_reg   <= done.addr;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_payload_address = m_addr_reg;

endmodule

@@ src/ifla_tag_ram.sv @@
module ifla_tag_ram
    import ifla_pkg::*;
#(
    parameter int AW = 12
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [TAG_W-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [TAG_W-1:0] rdata
);

    logic [TAG_W-1:0] mem [2**AW];
    logic [TAG_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/ifla_engine.sv @@
module ifla_engine
    import ifla_pkg::*;
#(
    parameter int MAX_PAGES = MAX_PAGES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              restart,
    input  logic [$clog2(MAX_PAGES*WORDS_PER_PAGE):0] n_words,
    input  logic [BASE_W-1:0] base_page,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_operation,
    input  logic [13:0]       s_request_bytes,
    input  logic [31:0]       s_address,
    input  logic              out_free,
    output done_t             done
);

    localparam int AW = $clog2(MAX_PAGES * WORDS_PER_PAGE);
    localparam int LW = (AW + 1 > 13) ? AW + 1 : 13;
    localparam int TW = (LW > SIZE_W) ? LW : SIZE_W;

    state_t           state_reg, state_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [LW-1:0]    i_reg, i_next;
    logic [LW-1:0]    s_reg, s_next;
    logic [LW-1:0]    need_reg, need_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    logic             op_reg, op_next;
    status_t          stat_reg, stat_next;
    logic [31:0]      res_reg, res_next;

    logic             we, re;
    logic [AW-1:0]    waddr, raddr;
    logic [TAG_W-1:0] wdata, rdata;

    logic [LW-1:0]    n_ext, last_idx, cur_len, nx;
    logic [31:0]      start, off, bytes;
    logic             free_bad;
    logic [14:0]      need_w;

    function automatic logic [TAG_W-1:0] mk_tag(input logic [LW-1:0] size, input logic used);
        logic [TW-1:0] ext;
        ext = TW'(size);
        return {ext[SIZE_W-1:0], used};
    endfunction

    // Block length from a tag: at least one word, never past word n-2.
    function automatic logic [LW-1:0] blen(input logic [TAG_W-1:0] t,
                                           input logic [LW-1:0] idx,
                                           input logic [LW-1:0] last);
        logic [LW-1:0] s;
        logic [LW-1:0] room;
        s    = LW'(t[TAG_W-1:1]);
        room = last - idx;
        if (s == '0) begin
            s = LW'(1);
        end
        if (s > room) begin
            s = room;
        end
        return s;
    endfunction

    ifla_tag_ram #(.AW(AW)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign n_ext    = LW'(n_words);
    assign last_idx = n_ext - LW'(1);
    assign start    = {base_page, {PAGE_SHIFT{1'b0}}};
    assign off      = s_address - start;
    assign bytes    = {30'(n_words), 2'b00};
    assign free_bad = (s_address == 32'd0) || (off[1:0] != 2'b00) || (off < 32'd8) ||
                      (off >= bytes - 32'd4);
    assign need_w   = (({1'b0, s_request_bytes} + 15'd3) >> 2) + 15'd2;

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        i_next     = i_reg;
        s_next     = s_reg;
        need_next  = need_reg;
        tag_next   = tag_reg;
        op_next    = op_reg;
        stat_next  = stat_reg;
        res_next   = res_reg;
        we         = 1'b0;
        re         = 1'b0;
        waddr      = AW'(i_reg);
        raddr      = AW'(i_reg);
        wdata      = '0;
        s_ready    = 1'b0;
        done       = '{valid: 1'b0, status: stat_reg, addr: res_reg};
        cur_len    = blen(rdata, i_reg, last_idx);
        nx         = i_reg + s_reg;

        case (state_reg)
            ST_CLEAR: begin
                we    = 1'b1;
                waddr = clr_reg;
                if (LW'(clr_reg) == LW'(1) || LW'(clr_reg) == n_ext - LW'(2)) begin
                    wdata = mk_tag(n_ext - LW'(2), 1'b0);
                end
                clr_next = clr_reg + AW'(1);
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next  = s_operation;
                    res_next = '0;
                    if (s_operation == OP_ALLOC) begin
                        need_next = LW'(need_w);
                        i_next    = LW'(1);
                        if (s_request_bytes == '0) begin
                            stat_next  = STAT_BAD;
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_M_RD;
                        end
                    end else if (free_bad) begin
                        stat_next  = STAT_BAD;
                        state_next = ST_DONE;
                    end else begin
                        i_next     = LW'(off[31:2]) - LW'(1);
                        state_next = ST_F_RD;
                    end
                end
            end
            ST_F_RD: begin
                re         = 1'b1;
                state_next = ST_F_CHK;
            end
            ST_F_CHK: begin
                we         = 1'b1;
                wdata      = {rdata[TAG_W-1:1], 1'b0};
                tag_next   = {rdata[TAG_W-1:1], 1'b0};
                s_next     = cur_len;
                state_next = ST_F_W2;
            end
            ST_F_W2: begin
                we         = 1'b1;
                waddr      = AW'(i_reg + s_reg - LW'(1));
                wdata      = tag_reg;
                i_next     = LW'(1);
                state_next = ST_M_RD;
            end
            ST_M_RD: begin
                if (i_reg < last_idx) begin
                    re         = 1'b1;
                    state_next = ST_M_CHK;
                end else if (op_reg == OP_ALLOC) begin
                    i_next     = LW'(1);
                    state_next = ST_A_RD;
                end else begin
                    stat_next  = STAT_OK;
                    state_next = ST_DONE;
                end
            end
            ST_M_CHK: begin
                if (!rdata[0] && (i_reg + cur_len < last_idx)) begin
                    re         = 1'b1;
                    raddr      = AW'(i_reg + cur_len);
                    s_next     = cur_len;
                    state_next = ST_M_NXT;
                end else begin
                    i_next     = i_reg + cur_len;
                    state_next = ST_M_RD;
                end
            end
            ST_M_NXT: begin
                // If the neighbor is free, the merged size goes into both end tags.
                if (rdata[0]) begin
                    i_next     = nx;
                    state_next = ST_M_RD;
                end else begin
                    s_next     = s_reg + blen(rdata, nx, last_idx);
                    state_next = ST_M_W1;
                end
            end
            ST_M_W1: begin
                we         = 1'b1;
                wdata      = mk_tag(s_reg, 1'b0);
                state_next = ST_M_W2;
            end
            ST_M_W2: begin
                we         = 1'b1;
                waddr      = AW'(i_reg + s_reg - LW'(1));
                wdata      = mk_tag(s_reg, 1'b0);
                state_next = ST_M_RD;
            end
            ST_A_RD: begin
                if (i_reg < last_idx) begin
                    re         = 1'b1;
                    state_next = ST_A_CHK;
                end else begin
                    stat_next  = STAT_NOFIT;
                    state_next = ST_DONE;
                end
            end
            ST_A_CHK: begin
                if (!rdata[0] && need_reg <= cur_len) begin
                    we         = 1'b1;
                    wdata      = mk_tag(need_reg, 1'b1);
                    s_next     = cur_len;
                    state_next = ST_A_W2;
                end else begin
                    i_next     = i_reg + cur_len;
                    state_next = ST_A_RD;
                end
            end
            ST_A_W2: begin
                we    = 1'b1;
                waddr = AW'(i_reg + need_reg - LW'(1));
                wdata = mk_tag(need_reg, 1'b1);
                if (s_reg > need_reg) begin
                    state_next = ST_A_W3;
                end else begin
                    stat_next  = STAT_OK;
                    res_next   = start + {30'(i_reg + LW'(1)), 2'b00};
                    state_next = ST_DONE;
                end
            end
            ST_A_W3: begin
                we         = 1'b1;
                waddr      = AW'(i_reg + need_reg);
                wdata      = mk_tag(s_reg - need_reg, 1'b0);
                state_next = ST_A_W4;
            end
            ST_A_W4: begin
                we         = 1'b1;
                waddr      = AW'(i_reg + s_reg - LW'(1));
                wdata      = mk_tag(s_reg - need_reg, 1'b0);
                stat_next  = STAT_OK;
                res_next   = start + {30'(i_reg + LW'(1)), 2'b00};
                state_next = ST_DONE;
            end
            ST_DONE: begin
                done.valid = 1'b1;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A new heap length lays the heap out again from word 0.
        if (restart) begin
            state_next = ST_CLEAR;
            clr_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg    <= i_next;
        s_reg    <= s_next;
        need_reg <= need_next;
        tag_reg  <= tag_next;
        op_reg   <= op_next;
        stat_reg <= stat_next;
        res_reg  <= res_next;
    end

endmodule

@@ src/ifla_checker.sv @@
`include "assert_macros.svh"

module ifla_checker
    import ifla_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [1:0]       m_status,
    input logic [31:0]      m_payload_address
);

    // A result word that is held back keeps its payload.
    `ASSERT_CLKD(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_payload_address) && $stable(m_status), "stalled result word changed")

    // Only successful allocations carry an address.
    `ASSERT_CLKD(a_addr_zero, aclk, aresetn, m_valid && m_status != STAT_OK |-> m_payload_address == 32'd0, "failed request returned an address")

    // Payload addresses are word aligned.
    `ASSERT_CLKD(a_addr_align, aclk, aresetn, m_valid |-> m_payload_address[1:0] == 2'b00, "payload address not word aligned")

    // The block works on one request at a time.
    `ASSERT_CLKD(a_one_at_time, aclk, aresetn, s_valid && s_ready |=> !s_ready, "request taken while another is in progress")

endmodule

bind implicit_free_list_allocator ifla_checker u_ifla_checker (.*);

@@ sim/ifla_checker.sv @@
module ifla_monitor
    import ifla_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic             s_operation,
    input  logic [13:0]      s_request_bytes,
    input  logic [31:0]      s_address,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic [1:0]       m_status,
    input  logic [31:0]      m_payload_address,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    output int               failures,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = MAX_PAGES_DEF * WORDS_PER_PAGE;

    logic [TAG_W-1:0]  heap_tags [0:DEPTH-1];
    logic [BASE_W-1:0] base_page;
    int unsigned       page_count;

    status_t     awaited_status [$];
    logic [31:0] awaited_addr [$];

    function automatic int unsigned heap_len();
        return page_count * WORDS_PER_PAGE;
    endfunction

    function automatic logic [TAG_W-1:0] pack_tag(int unsigned size, logic used);
        logic [SIZE_W-1:0] sz;
        sz = size[SIZE_W-1:0];
        return {sz, used};
    endfunction

    function automatic logic is_used(int unsigned i);
        return heap_tags[i % DEPTH][0];
    endfunction

    // Block size at word i, at least one word and never past the last tag slot.
    function automatic int unsigned span_at(int unsigned i);
        int unsigned s;
        int unsigned room;
        s = heap_tags[i % DEPTH][TAG_W-1:1];
        room = heap_len() - 1 - i;
        if (s == 0) s = 1;
        if (s > room) s = room;
        return s;
    endfunction

    function automatic void set_tag(int unsigned i, logic [TAG_W-1:0] t);
        heap_tags[i % DEPTH] = t;
    endfunction

    function automatic void init_layout();
        int unsigned n;
        n = heap_len();
        for (int k = 0; k < DEPTH; k++) heap_tags[k] = '0;
        set_tag(1, pack_tag(n - 2, 1'b0));
        set_tag(n - 2, pack_tag(n - 2, 1'b0));
    endfunction

    function automatic void coalesce();
        int unsigned n;
        int unsigned i;
        int unsigned s;
        int unsigned nx;
        int unsigned ns;
        logic [TAG_W-1:0] t;
        n = heap_len();
        i = 1;
        while (i < n - 1) begin
            s = span_at(i);
            if (!is_used(i)) begin
                nx = i + s;
                if (nx < n - 1 && !is_used(nx)) begin
                    ns = s + span_at(nx);
                    t = pack_tag(ns, 1'b0);
                    set_tag(i, t);
                    set_tag(i + ns - 1, t);
                    continue;
                end
            end
            i += s;
        end
    endfunction

    function automatic void serve_request(input logic op, input logic [13:0] req,
                                          input logic [31:0] addr,
                                          output status_t st, output logic [31:0] pa);
        int unsigned n;
        int unsigned need;
        int unsigned i;
        int unsigned cs;
        int unsigned h;
        logic [31:0] start;
        logic [31:0] off;
        logic [31:0] bytes;
        logic [TAG_W-1:0] t;
        n = heap_len();
        start = {base_page, 12'h000};
        st = STAT_OK;
        pa = '0;
        if (op == OP_ALLOC) begin
            if (req == 0) begin
                st = STAT_BAD;
            end else begin
                need = ((int'(req) + 3) >> 2) + 2;
                st = STAT_NOFIT;
                coalesce();
                i = 1;
                while (i < n - 1) begin
                    cs = span_at(i);
                    if (!is_used(i) && need <= cs) begin
                        t = pack_tag(need, 1'b1);
                        set_tag(i, t);
                        set_tag(i + need - 1, t);
                        if (cs > need) begin
                            t = pack_tag(cs - need, 1'b0);
                            set_tag(i + need, t);
                            set_tag(i + cs - 1, t);
                        end
                        st = STAT_OK;
                        pa = start + 32'(4 * (i + 1));
                        break;
                    end
                    i += cs;
                end
            end
        end else begin
            off = addr - start;
            bytes = 32'(n * 4);
            if (addr == 0 || off[1:0] != 2'b00 || off < 8 || off >= bytes - 4) begin
                st = STAT_BAD;
            end else begin
                h = (off >> 2) - 1;
                t = heap_tags[h % DEPTH] & 15'h7FFE;
                cs = span_at(h);
                set_tag(h, t);
                set_tag(h + cs - 1, t);
                coalesce();
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: %s mismatch: expected 0x%08h, got 0x%08h", $realtime, what, want, got);
        failures++;
    endtask

    initial begin
        failures = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        status_t     st;
        logic [31:0] pa;
        int unsigned p;
        if (!aresetn) begin
            base_page = '0;
            page_count = HEAP_PAGES_RST;
            init_layout();
            awaited_status.delete();
            awaited_addr.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_BASE) begin
                    base_page = cfg_wdata[BASE_W-1:0];
                end else begin
                    p = cfg_wdata[2:0];
                    if (p == 0) p = 1;
                    if (p > MAX_PAGES_DEF) p = MAX_PAGES_DEF;
                    page_count = p;
                    init_layout();
                end
            end
            if (m_valid && m_ready) begin
                if (awaited_status.size() == 0) begin
                    report_mismatch("unexpected word, status", 32'hFFFFFFFF, 32'(m_status));
                end else begin
                    st = awaited_status.pop_front();
                    pa = awaited_addr.pop_front();
                    if (m_status !== st) report_mismatch("status", 32'(st), 32'(m_status));
                    if (m_payload_address !== pa)
                        report_mismatch("payload address", pa, m_payload_address);
                end
            end
            if (s_valid && s_ready) begin
                serve_request(s_operation, s_request_bytes, s_address, st, pa);
                awaited_status.push_back(st);
                awaited_addr.push_back(pa);
            end
        end
        pending = awaited_status.size();
    end

endmodule

@@ sim/implicit_free_list_allocator_test.sv @@
module implicit_free_list_allocator_test;
    import ifla_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic             s_operation;
    logic [13:0]      s_request_bytes;
    logic [31:0]      s_address;
    logic             m_valid;
    logic             m_ready;
    logic [1:0]       m_status;
    logic [31:0]      m_payload_address;
    logic             cfg_we;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_wdata;
    int               failures;
    int               pending;

    logic        s_fire;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_requests;
    int          holds_served;
    int          hold_left;
    logic [31:0] live_blocks [$];
    logic [19:0] cur_base;
    int unsigned cur_words;

    implicit_free_list_allocator u_dut (.*);

    ifla_monitor u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #1000ms;
        $display("implicit_free_list_allocator test failed");
        $finish;
    end

    always @(posedge aclk) begin
        s_fire <= aresetn && s_valid && s_ready;
        // Successful allocations feed the well-formed frees.
        if (aresetn && m_valid && m_ready && m_status == STAT_OK && m_payload_address != 0)
            live_blocks.push_back(m_payload_address);
    end

    // Receiver: random stalls, plus long hold-offs on request to back up the block.
    initial begin
        m_ready = 1'b0;
        hold_left = 0;
        holds_served = 0;
        forever begin
            @(negedge aclk);
            if (hold_left == 0 && holds_served != hold_requests) begin
                hold_left = 400;
                holds_served++;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_word(input logic op, input logic [13:0] bytes_req,
                             input logic [31:0] addr);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_request_bytes <= bytes_req;
        s_address <= addr;
        do @(negedge aclk); while (!s_fire);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_word();
        int unsigned pick;
        int unsigned k;
        logic [31:0] start;
        logic [13:0] sz;
        start = {cur_base, 12'h000};
        pick = $urandom_range(99);
        if (live_blocks.size() > 40 && pick < 45) pick = 50;
        if (pick < 45 || (pick < 85 && live_blocks.size() == 0)) begin
            k = $urandom_range(99);
            if (k < 70) sz = 14'($urandom_range(64, 1));
            else if (k < 90) sz = 14'($urandom_range(1024, 65));
            else if (k < 98) sz = 14'($urandom_range(16383, 1025));
            else sz = '0;
            send_word(OP_ALLOC, sz, $urandom);
        end else if (pick < 85) begin
            k = $urandom_range(live_blocks.size() - 1);
            send_word(OP_FREE, 14'($urandom), live_blocks[k]);
            // Now and then the block is kept in the list so it gets freed twice.
            if ($urandom_range(19) != 0) live_blocks.delete(k);
        end else begin
            k = $urandom_range(3);
            case (k)
                0: send_word(OP_FREE, 14'($urandom), $urandom);
                1: send_word(OP_FREE, 14'($urandom), start + 4 * $urandom_range(cur_words));
                2: send_word(OP_FREE, 14'($urandom), start + $urandom_range(4 * cur_words));
                default: send_word(OP_FREE, 14'($urandom), 32'h0);
            endcase
        end
    endtask

    initial begin
        logic [19:0] bases [8];
        logic [2:0]  pages [8];
        int unsigned p;
        bases = '{20'hFFFFF, 20'h12345, 20'h00000, 20'h0, 20'hFFFFF, 20'h0, 20'h80000, 20'h0};
        pages = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd4, 3'd3, 3'd5, 3'd4};
        bases[3] = 20'($urandom);
        bases[5] = 20'($urandom);
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_operation = OP_ALLOC;
        s_request_bytes = '0;
        s_address = '0;
        cfg_we = 1'b0;
        cfg_index = REG_BASE;
        cfg_wdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_requests = 0;
        cur_base = '0;
        cur_words = HEAP_PAGES_RST * WORDS_PER_PAGE;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed corner cases on the reset layout (base 0, four pages).
        send_word(OP_ALLOC, 14'd0, 32'h0);
        send_word(OP_ALLOC, 14'd16383, 32'h0);
        send_word(OP_ALLOC, 14'd16368, 32'h0);
        send_word(OP_ALLOC, 14'd1, 32'h0);
        send_word(OP_FREE, 14'd0, 32'd8);
        send_word(OP_ALLOC, 14'd1, 32'h0);
        send_word(OP_ALLOC, 14'd4, 32'h0);
        send_word(OP_ALLOC, 14'd5, 32'h0);
        send_word(OP_FREE, 14'd0, 32'd12);
        send_word(OP_FREE, 14'd0, 32'd0);
        send_word(OP_FREE, 14'd0, 32'd6);
        send_word(OP_FREE, 14'd0, 32'd4);
        send_word(OP_FREE, 14'd0, 32'd16380);
        send_word(OP_FREE, 14'd0, 32'd16376);
        send_word(OP_FREE, 14'd0, 32'd8);
        send_word(OP_FREE, 14'd0, 32'd8);
        send_word(OP_FREE, 14'h3FFF, 32'hFFFFFFFF);
        send_word(OP_FREE, 14'd0, 32'h80000000);
        send_word(OP_ALLOC, 14'd100, 32'hFFFFFFFF);
        send_word(OP_FREE, 14'd0, 32'd8);
        send_word(OP_ALLOC, 14'd3, 32'h0);
        repeat (200) random_word();
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            live_blocks.delete();
            write_reg(REG_BASE, CFG_W'(bases[ph]));
            write_reg(REG_PAGES, CFG_W'(pages[ph]));
            p = pages[ph];
            if (p == 0) p = 1;
            if (p > MAX_PAGES_DEF) p = MAX_PAGES_DEF;
            cur_base = bases[ph];
            cur_words = p * WORDS_PER_PAGE;
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            if (ph == 0 || ph == 4) hold_requests++;
            repeat (220) random_word();
            drain();
        end

        if (failures == 0) begin
            $display("implicit_free_list_allocator test passed");
        end else begin
            $display("implicit_free_list_allocator test failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/ifla_pkg.sv
src/ifla_tag_ram.sv
src/ifla_engine.sv
src/implicit_free_list_allocator.sv
src/ifla_checker.sv
sim/ifla_checker.sv
sim/implicit_free_list_allocator_test.sv
